[rtl/gzmh_pkg.sv]
// Shared constants, a result type and a helper function for the gzip member header checker.
package gzmh_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] MIN_MEMBER = 32'd18;
  localparam logic [31:0] TRAILER_LEN = 32'd8;
  localparam logic [31:0] FIXED_END  = 32'd9;

  localparam logic [7:0] MAGIC1_BYTE   = 8'h1F;
  localparam logic [7:0] MAGIC2_BYTE   = 8'h8B;
  localparam logic [7:0] METHOD_DEFL   = 8'h08;
  localparam logic [7:0] FLG_RESERVED  = 8'hE0;
  localparam logic [7:0] FLG_FEXTRA    = 8'h04;
  localparam logic [7:0] FLG_FNAME     = 8'h08;
  localparam logic [7:0] FLG_FCOMMENT  = 8'h10;
  localparam logic [7:0] FLG_FHCRC     = 8'h02;

  // Parse phase codes.
  localparam logic [3:0] PH_MAGIC1    = 4'd0;
  localparam logic [3:0] PH_MAGIC2    = 4'd1;
  localparam logic [3:0] PH_METHOD    = 4'd2;
  localparam logic [3:0] PH_FLAGS     = 4'd3;
  localparam logic [3:0] PH_FIXED     = 4'd4;
  localparam logic [3:0] PH_XLEN_LO   = 4'd5;
  localparam logic [3:0] PH_XLEN_HI   = 4'd6;
  localparam logic [3:0] PH_EXTRA     = 4'd7;
  localparam logic [3:0] PH_NAME      = 4'd8;
  localparam logic [3:0] PH_COMMENT   = 4'd9;
  localparam logic [3:0] PH_HCRC_LO   = 4'd10;
  localparam logic [3:0] PH_HCRC_HI   = 4'd11;
  localparam logic [3:0] PH_PAY_FIRST = 4'd12;
  localparam logic [3:0] PH_PAYLOAD   = 4'd13;
  localparam logic [3:0] PH_TRAILER   = 4'd14;
  localparam logic [3:0] PH_DISCARD   = 4'd15;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_HDR   = 3'd2;
  localparam logic [2:0] ST_HCRC  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [31:0] stored_size;
    logic [31:0] stored_crc;
    logic [2:0]  status;
    logic        done_res;
    logic [7:0]  payload_byte;
  } result_t;

  // Picks the next optional header section present after the given phase.
  function automatic logic [3:0] next_phase(input logic [3:0] from, input logic [7:0] flags);
    logic [3:0] ph;
    ph = PH_PAY_FIRST;
    if (from <= PH_COMMENT && (flags & FLG_FHCRC) != 8'h00) ph = PH_HCRC_LO;
    if (from <= PH_NAME && (flags & FLG_FCOMMENT) != 8'h00) ph = PH_COMMENT;
    if (from <= PH_EXTRA && (flags & FLG_FNAME) != 8'h00) ph = PH_NAME;
    if (from <= PH_FIXED && (flags & FLG_FEXTRA) != 8'h00) ph = PH_XLEN_LO;
    return ph;
  endfunction

endpackage

[rtl/gzmh_crc.sv]
// Byte-wide reflected CRC-32 update, unrolled over the eight bit steps.
module gzmh_crc (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_byte,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'h000000, data_byte};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (gzmh_pkg::CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

[rtl/gzmh_parser.sv]
// Header parse state and per-byte next-state and result logic.
module gzmh_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_acc,
  input  logic [7:0]              data_byte,
  input  logic [31:0]             member_length,
  output logic                    res_valid,
  output gzmh_pkg::result_t       res
);

  localparam int LB = LENGTH_BITS;

  logic [LB-1:0] pos_r, pos_nxt;
  logic [3:0]    phase_r, phase_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [15:0]   xrem_r, xrem_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [7:0]    hlow_r, hlow_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [63:0]   trl_r, trl_nxt;

  logic [LB-1:0] len_sat, len_eff, tstart;
  logic          short_mem, in_trl, last_byte, fixed_done;
  logic [31:0]   crc_upd;
  logic          do_fail, pay;
  logic [2:0]    fail_code, st;
  logic [15:0]   xlen;

  // Lengths beyond the position counter saturate to its largest value.
  generate
    if (LB >= 32) begin : g_wide
      assign len_sat = LB'(member_length);
    end else begin : g_narrow
      assign len_sat = (|member_length[31:LB]) ? {LB{1'b1}} : member_length[LB-1:0];
    end
  endgenerate

  assign len_eff    = (len_sat == '0) ? LB'(1) : len_sat;
  assign short_mem  = len_eff < LB'(gzmh_pkg::MIN_MEMBER);
  assign tstart     = len_eff - LB'(gzmh_pkg::TRAILER_LEN);
  assign in_trl     = !short_mem && (pos_r >= tstart);
  assign last_byte  = pos_r >= (len_eff - LB'(1));
  assign fixed_done = pos_r >= LB'(gzmh_pkg::FIXED_END);
  assign xlen       = {data_byte, xrem_r[7:0]};

  gzmh_crc u_crc (
    .crc_in    (crc_r),
    .data_byte (data_byte),
    .crc_out   (crc_upd)
  );

  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    xrem_nxt  = xrem_r;
    crc_nxt   = crc_r;
    hlow_nxt  = hlow_r;
    err_nxt   = err_r;
    trl_nxt   = trl_r;
    pos_nxt   = pos_r + LB'(1);
    do_fail   = 1'b0;
    fail_code = gzmh_pkg::ST_OK;
    pay       = 1'b0;

    if (!short_mem) begin
      if (in_trl) trl_nxt = {data_byte, trl_r[63:8]};
      if (phase_r < gzmh_pkg::PH_PAY_FIRST && in_trl) begin
        // The header ran into the trailer.
        do_fail   = 1'b1;
        fail_code = (phase_r >= gzmh_pkg::PH_HCRC_LO) ? gzmh_pkg::ST_HCRC : gzmh_pkg::ST_HDR;
      end else if (phase_r == gzmh_pkg::PH_PAY_FIRST || phase_r == gzmh_pkg::PH_PAYLOAD) begin
        if (in_trl) begin
          if (phase_r == gzmh_pkg::PH_PAY_FIRST) begin
            do_fail   = 1'b1;
            fail_code = gzmh_pkg::ST_EMPTY;
          end else begin
            phase_nxt = gzmh_pkg::PH_TRAILER;
          end
        end else begin
          pay       = 1'b1;
          phase_nxt = gzmh_pkg::PH_PAYLOAD;
        end
      end else if (phase_r < gzmh_pkg::PH_PAY_FIRST) begin
        if (phase_r <= gzmh_pkg::PH_COMMENT) crc_nxt = crc_upd;
        unique case (phase_r)
          gzmh_pkg::PH_MAGIC1: begin
            if (data_byte != gzmh_pkg::MAGIC1_BYTE) begin
              do_fail = 1'b1; fail_code = gzmh_pkg::ST_HDR;
            end else phase_nxt = gzmh_pkg::PH_MAGIC2;
          end
          gzmh_pkg::PH_MAGIC2: begin
            if (data_byte != gzmh_pkg::MAGIC2_BYTE) begin
              do_fail = 1'b1; fail_code = gzmh_pkg::ST_HDR;
            end else phase_nxt = gzmh_pkg::PH_METHOD;
          end
          gzmh_pkg::PH_METHOD: begin
            if (data_byte != gzmh_pkg::METHOD_DEFL) begin
              do_fail = 1'b1; fail_code = gzmh_pkg::ST_HDR;
            end else phase_nxt = gzmh_pkg::PH_FLAGS;
          end
          gzmh_pkg::PH_FLAGS: begin
            flag_nxt = data_byte;
            if ((data_byte & gzmh_pkg::FLG_RESERVED) != 8'h00) begin
              do_fail = 1'b1; fail_code = gzmh_pkg::ST_HDR;
            end else phase_nxt = gzmh_pkg::PH_FIXED;
          end
          gzmh_pkg::PH_FIXED: begin
            if (fixed_done)
              phase_nxt = gzmh_pkg::next_phase(gzmh_pkg::PH_FIXED, flag_r);
          end
          gzmh_pkg::PH_XLEN_LO: begin
            xrem_nxt  = {8'h00, data_byte};
            phase_nxt = gzmh_pkg::PH_XLEN_HI;
          end
          gzmh_pkg::PH_XLEN_HI: begin
            xrem_nxt  = xlen;
            phase_nxt = (xlen == 16'h0000) ?
                        gzmh_pkg::next_phase(gzmh_pkg::PH_EXTRA, flag_r) : gzmh_pkg::PH_EXTRA;
          end
          gzmh_pkg::PH_EXTRA: begin
            xrem_nxt = xrem_r - 16'd1;
            if (xrem_r == 16'd1)
              phase_nxt = gzmh_pkg::next_phase(gzmh_pkg::PH_EXTRA, flag_r);
          end
          gzmh_pkg::PH_NAME: begin
            if (data_byte == 8'h00)
              phase_nxt = gzmh_pkg::next_phase(gzmh_pkg::PH_NAME, flag_r);
          end
          gzmh_pkg::PH_COMMENT: begin
            if (data_byte == 8'h00)
              phase_nxt = gzmh_pkg::next_phase(gzmh_pkg::PH_COMMENT, flag_r);
          end
          gzmh_pkg::PH_HCRC_LO: begin
            hlow_nxt  = data_byte;
            phase_nxt = gzmh_pkg::PH_HCRC_HI;
          end
          default: begin
            // Stored header CRC is the low half of the final CRC-32.
            if (~crc_r[15:0] != {data_byte, hlow_r}) begin
              do_fail = 1'b1; fail_code = gzmh_pkg::ST_HCRC;
            end else phase_nxt = gzmh_pkg::PH_PAY_FIRST;
          end
        endcase
      end
    end

    if (do_fail) begin
      phase_nxt = gzmh_pkg::PH_DISCARD;
      if (err_r == gzmh_pkg::ST_OK) err_nxt = fail_code;
    end

    st = short_mem ? gzmh_pkg::ST_SHORT : err_nxt;

    res_valid = pay || last_byte;
    res       = '0;
    if (last_byte) begin
      res.done_res = 1'b1;
      res.status   = st;
      if (st == gzmh_pkg::ST_OK) begin
        res.stored_crc  = trl_nxt[31:0];
        res.stored_size = trl_nxt[63:32];
      end
    end else begin
      res.payload_byte = data_byte;
    end

    // The last byte of a member returns everything to its start values.
    if (last_byte) begin
      pos_nxt   = '0;
      phase_nxt = gzmh_pkg::PH_MAGIC1;
      flag_nxt  = 8'h00;
      xrem_nxt  = 16'h0000;
      crc_nxt   = gzmh_pkg::CRC_INIT;
      hlow_nxt  = 8'h00;
      err_nxt   = gzmh_pkg::ST_OK;
      trl_nxt   = 64'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= gzmh_pkg::PH_MAGIC1;
      flag_r  <= 8'h00;
      xrem_r  <= 16'h0000;
      crc_r   <= gzmh_pkg::CRC_INIT;
      hlow_r  <= 8'h00;
      err_r   <= gzmh_pkg::ST_OK;
      trl_r   <= 64'h0;
    end else if (byte_acc) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      xrem_r  <= xrem_nxt;
      crc_r   <= crc_nxt;
      hlow_r  <= hlow_nxt;
      err_r   <= err_nxt;
      trl_r   <= trl_nxt;
    end
  end

endmodule

[rtl/gzmh_out_reg.sv]
// Result register that decouples the output stream from the parser.
module gzmh_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              load_valid,
  input  gzmh_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output gzmh_pkg::result_t out_res,
  output logic              can_load
);

  logic              valid_r, valid_nxt;
  gzmh_pkg::result_t res_r;

  // A new word may enter whenever the held one is empty or leaving.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? load_valid : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) res_r <= load_res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[rtl/gzip_member_header_checker_top.sv]
// Top level of the gzip member header checker.
// Takes one byte of a single-member gzip stream per cycle; each byte is parsed by shallow
// logic in the same cycle it is accepted and its result lands in one output register, so
// a result appears in the cycle after its byte and the block sustains one byte per clock as
// long as the output side keeps taking words. Header bytes, trailer bytes and skipped
// fields give no output word; each deflate payload byte gives one word, and the member's
// last byte gives a final word with tlast high carrying the status and, when the status is
// ok, the stored CRC-32 and size. The member length register should be written only while
// no member is in progress.
module gzip_member_header_checker_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] payload_byte, [10:8] status,
                                  // [42:11] stored_crc, [74:43] stored_size, rest zero
  output logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // member_length
);

  logic              byte_acc;
  logic              res_valid;
  gzmh_pkg::result_t res;
  gzmh_pkg::result_t out_res;
  logic              can_load;
  logic [31:0]       member_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)                      member_length_r <= gzmh_pkg::MIN_MEMBER;
    else if (cfg_valid && cfg_ready) member_length_r <= cfg_data;
  end

  assign in_tready = can_load;
  assign byte_acc  = in_tvalid && in_tready;

  gzmh_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_acc      (byte_acc),
    .data_byte     (in_tdata),
    .member_length (member_length_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  gzmh_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (byte_acc),
    .load_valid (res_valid),
    .load_res   (res),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .can_load   (can_load)
  );

  assign out_tdata = {5'b00000, out_res.stored_size, out_res.stored_crc,
                      out_res.status, out_res.payload_byte};
  assign out_tlast = out_res.done_res;

  // Failed members report no trailer values.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && out_tdata[10:8] != gzmh_pkg::ST_OK) |->
      (out_tdata[74:11] == 64'h0))
    else $error("trailer fields nonzero on error status");

  // Payload words carry only the byte.
  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[79:8] == 72'h0))
    else $error("payload word carries status or trailer bits");

  // Status stays within its defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[10:8] <= gzmh_pkg::ST_EMPTY))
    else $error("undefined status code");

  // An empty output register never holds off the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

[tb/sv/tb_gzip_member_header_checker_top.sv]
// Self-checking testbench for the gzip member header checker: random members, checked per word.
module tb_gzip_member_header_checker_top;

  localparam int unsigned RUN_LIMIT = 2000000;

  typedef enum int {MEMBER_CLEAN, MEMBER_FLIPPED, MEMBER_BAD_HCRC, MEMBER_NOISE} member_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;   // [7:0] payload_byte, [10:8] status, [42:11] stored_crc,
                            // [74:43] stored_size, rest zero
  logic        out_tlast;   // done_res
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;    // member_length

  gzip_member_header_checker_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Bytes waiting to be sent and the results the parser model says they cause.
  logic [7:0]        member_bytes[$];
  gzmh_pkg::result_t member_results_due[$];

  // Parser model state.
  logic [31:0]     cfg_length = gzmh_pkg::MIN_MEMBER;
  longint unsigned gz_pos;
  logic [3:0]      gz_phase;
  logic [7:0]      gz_flags;
  logic [15:0]     gz_extra_left;
  logic [31:0]     gz_crc;
  logic [7:0]      gz_crc_lo;
  logic [2:0]      gz_error;
  logic [63:0]     gz_tail;

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  bit          idle_on;
  int unsigned drv_gap = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned words_checked = 0;
  int unsigned length_writes = 0;
  int unsigned status_count[0:7];

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h000000, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ gzmh_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // First optional header section that the flags enable after the given phase.
  function automatic logic [3:0] section_after(input logic [3:0] from);
    if (from <= gzmh_pkg::PH_FIXED && (gz_flags & gzmh_pkg::FLG_FEXTRA) != 8'h00)
      return gzmh_pkg::PH_XLEN_LO;
    if (from <= gzmh_pkg::PH_EXTRA && (gz_flags & gzmh_pkg::FLG_FNAME) != 8'h00)
      return gzmh_pkg::PH_NAME;
    if (from <= gzmh_pkg::PH_NAME && (gz_flags & gzmh_pkg::FLG_FCOMMENT) != 8'h00)
      return gzmh_pkg::PH_COMMENT;
    if (from <= gzmh_pkg::PH_COMMENT && (gz_flags & gzmh_pkg::FLG_FHCRC) != 8'h00)
      return gzmh_pkg::PH_HCRC_LO;
    return gzmh_pkg::PH_PAY_FIRST;
  endfunction

  task automatic clear_parse();
    gz_pos = 0;
    gz_phase = gzmh_pkg::PH_MAGIC1;
    gz_flags = 8'h00;
    gz_extra_left = 16'h0000;
    gz_crc = gzmh_pkg::CRC_INIT;
    gz_crc_lo = 8'h00;
    gz_error = gzmh_pkg::ST_OK;
    gz_tail = 64'h0;
  endtask

  task automatic latch_error(input logic [2:0] code);
    if (gz_error == gzmh_pkg::ST_OK) gz_error = code;
    gz_phase = gzmh_pkg::PH_DISCARD;
  endtask

  task automatic parse_gzip_byte(input logic [7:0] b);
    longint unsigned len;
    longint unsigned tstart;
    bit short_member;
    gzmh_pkg::result_t r;
    len = (cfg_length == 32'd0) ? 1 : cfg_length;
    short_member = len < gzmh_pkg::MIN_MEMBER;
    tstart = short_member ? 0 : len - gzmh_pkg::TRAILER_LEN;
    if (!short_member) begin
      if (gz_pos >= tstart) gz_tail = {b, gz_tail[63:8]};
      if (gz_phase < gzmh_pkg::PH_PAY_FIRST && gz_pos >= tstart) begin
        latch_error(gz_phase >= gzmh_pkg::PH_HCRC_LO ? gzmh_pkg::ST_HCRC : gzmh_pkg::ST_HDR);
      end else if (gz_phase == gzmh_pkg::PH_PAY_FIRST || gz_phase == gzmh_pkg::PH_PAYLOAD) begin
        if (gz_pos >= tstart) begin
          if (gz_phase == gzmh_pkg::PH_PAY_FIRST) latch_error(gzmh_pkg::ST_EMPTY);
          else gz_phase = gzmh_pkg::PH_TRAILER;
        end else begin
          r = '0;
          r.payload_byte = b;
          member_results_due.push_back(r);
          gz_phase = gzmh_pkg::PH_PAYLOAD;
        end
      end else if (gz_phase < gzmh_pkg::PH_PAY_FIRST) begin
        if (gz_phase <= gzmh_pkg::PH_COMMENT) gz_crc = crc32_step(gz_crc, b);
        case (gz_phase)
          gzmh_pkg::PH_MAGIC1:
            if (b != gzmh_pkg::MAGIC1_BYTE) latch_error(gzmh_pkg::ST_HDR);
            else gz_phase = gzmh_pkg::PH_MAGIC2;
          gzmh_pkg::PH_MAGIC2:
            if (b != gzmh_pkg::MAGIC2_BYTE) latch_error(gzmh_pkg::ST_HDR);
            else gz_phase = gzmh_pkg::PH_METHOD;
          gzmh_pkg::PH_METHOD:
            if (b != gzmh_pkg::METHOD_DEFL) latch_error(gzmh_pkg::ST_HDR);
            else gz_phase = gzmh_pkg::PH_FLAGS;
          gzmh_pkg::PH_FLAGS: begin
            gz_flags = b;
            if ((b & gzmh_pkg::FLG_RESERVED) != 8'h00) latch_error(gzmh_pkg::ST_HDR);
            else gz_phase = gzmh_pkg::PH_FIXED;
          end
          gzmh_pkg::PH_FIXED:
            if (gz_pos >= gzmh_pkg::FIXED_END) gz_phase = section_after(gzmh_pkg::PH_FIXED);
          gzmh_pkg::PH_XLEN_LO: begin
            gz_extra_left = {8'h00, b};
            gz_phase = gzmh_pkg::PH_XLEN_HI;
          end
          gzmh_pkg::PH_XLEN_HI: begin
            gz_extra_left = {b, gz_extra_left[7:0]};
            gz_phase = (gz_extra_left == 16'h0000) ? section_after(gzmh_pkg::PH_EXTRA) :
                                                     gzmh_pkg::PH_EXTRA;
          end
          gzmh_pkg::PH_EXTRA: begin
            gz_extra_left = gz_extra_left - 16'd1;
            if (gz_extra_left == 16'h0000) gz_phase = section_after(gzmh_pkg::PH_EXTRA);
          end
          gzmh_pkg::PH_NAME:
            if (b == 8'h00) gz_phase = section_after(gzmh_pkg::PH_NAME);
          gzmh_pkg::PH_COMMENT:
            if (b == 8'h00) gz_phase = section_after(gzmh_pkg::PH_COMMENT);
          gzmh_pkg::PH_HCRC_LO: begin
            gz_crc_lo = b;
            gz_phase = gzmh_pkg::PH_HCRC_HI;
          end
          gzmh_pkg::PH_HCRC_HI: begin
            if (~gz_crc[15:0] != {b, gz_crc_lo}) latch_error(gzmh_pkg::ST_HCRC);
            else gz_phase = gzmh_pkg::PH_PAY_FIRST;
          end
          default: ;
        endcase
      end
    end
    if (gz_pos + 1 >= len) begin
      r = '0;
      r.done_res = 1'b1;
      r.status = short_member ? gzmh_pkg::ST_SHORT : gz_error;
      if (r.status == gzmh_pkg::ST_OK) begin
        r.stored_crc = gz_tail[31:0];
        r.stored_size = gz_tail[63:32];
      end
      member_results_due.push_back(r);
      clear_parse();
    end else begin
      gz_pos = gz_pos + 1;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    member_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Queues nbytes of one member: a generated header (none for noise members), then random bytes.
  task automatic add_member(input int unsigned nbytes, input member_kind_t kind,
                            input logic [7:0] flags);
    logic [7:0]  hdr[$];
    logic [31:0] c;
    int unsigned n;
    int unsigned k;
    if (kind == MEMBER_BAD_HCRC) flags = flags | gzmh_pkg::FLG_FHCRC;
    hdr = '{gzmh_pkg::MAGIC1_BYTE, gzmh_pkg::MAGIC2_BYTE, gzmh_pkg::METHOD_DEFL, flags};
    repeat (6) hdr.push_back(8'($urandom_range(0, 255)));
    if ((flags & gzmh_pkg::FLG_FEXTRA) != 8'h00) begin
      n = $urandom_range(0, 5);
      hdr.push_back(n[7:0]);
      hdr.push_back(8'h00);
      repeat (n) hdr.push_back(8'($urandom_range(0, 255)));
    end
    if ((flags & gzmh_pkg::FLG_FNAME) != 8'h00) begin
      repeat ($urandom_range(0, 4)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if ((flags & gzmh_pkg::FLG_FCOMMENT) != 8'h00) begin
      repeat ($urandom_range(0, 4)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if ((flags & gzmh_pkg::FLG_FHCRC) != 8'h00) begin
      c = gzmh_pkg::CRC_INIT;
      foreach (hdr[i]) c = crc32_step(c, hdr[i]);
      c = ~c;
      if (kind == MEMBER_BAD_HCRC) c = c ^ (32'h1 << $urandom_range(0, 15));
      hdr.push_back(c[7:0]);
      hdr.push_back(c[15:8]);
    end
    if (kind == MEMBER_FLIPPED) begin
      k = $urandom_range(0, hdr.size() - 1);
      hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (k = 0; k < nbytes; k++) begin
      if (kind != MEMBER_NOISE && k < hdr.size()) queue_byte(hdr[k]);
      else queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 20)
      $display("cycle %0d: %s mismatch, expected 0x%0h, got 0x%0h",
               cycle_count, what, want, got);
  endtask

  task automatic write_length(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    length_writes++;
  endtask

  // Holds the sender until every queued byte is taken and every result has come back.
  task automatic settle();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || member_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Input side: one word in flight, random gaps between words while idle_on is set.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_tvalid <= 1'b0;
      end else if (member_bytes.size() > 0) begin
        in_tdata <= member_bytes.pop_front();
        in_tvalid <= 1'b1;
        drv_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin : watch
    gzmh_pkg::result_t got;
    gzmh_pkg::result_t want;
    in_fire <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_gzip_byte(in_tdata);
        bytes_taken++;
      end
      if (cfg_valid && cfg_ready) cfg_length = cfg_data;
      if (out_tvalid && out_tready) begin
        got.payload_byte = out_tdata[7:0];
        got.status = out_tdata[10:8];
        got.stored_crc = out_tdata[42:11];
        got.stored_size = out_tdata[74:43];
        got.done_res = out_tlast;
        if (member_results_due.size() == 0) begin
          report_mismatch("word with no result due, tdata[31:0]", 32'h0, out_tdata[31:0]);
        end else begin
          want = member_results_due.pop_front();
          if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", want.payload_byte, got.payload_byte);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", want.done_res, got.done_res);
          if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
          if (got.stored_crc !== want.stored_crc)
            report_mismatch("stored_crc", want.stored_crc, got.stored_crc);
          if (got.stored_size !== want.stored_size)
            report_mismatch("stored_size", want.stored_size, got.stored_size);
          words_checked++;
          if (want.done_res) status_count[want.status]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, member_results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned phase_bytes;
    int unsigned random_bytes;
    int unsigned r;
    member_kind_t kind;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 32'h0;
    idle_on = 1'b0;
    random_bytes = 0;
    foreach (status_count[i]) status_count[i] = 0;
    clear_parse();
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte members, a zero length (taken as one) and a minimal valid member.
    write_length(32'd1);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    settle();
    write_length(32'd0);
    queue_byte(gzmh_pkg::MAGIC1_BYTE);
    settle();
    write_length(32'd19);
    add_member(19, MEMBER_CLEAN, 8'h00);
    settle();

    // Random: each length setting carries whole members totalling at least 100 bytes, mostly well formed.
    while (random_bytes < 1000) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, 17);
      else if (r < 25) len = $urandom_range(18, 24);
      else if (r < 85) len = $urandom_range(25, 60);
      else len = $urandom_range(61, 400);
      idle_on = ($urandom_range(0, 3) != 0);
      write_length(len);
      phase_bytes = 0;
      do begin
        r = $urandom_range(0, 99);
        if (r < 70) kind = MEMBER_CLEAN;
        else if (r < 82) kind = MEMBER_FLIPPED;
        else if (r < 90) kind = MEMBER_BAD_HCRC;
        else kind = MEMBER_NOISE;
        add_member(len, kind, 8'($urandom_range(0, 31)));
        phase_bytes += len;
      end while (phase_bytes < 100);
      random_bytes += phase_bytes;
      settle();
    end

    // Largest length: the member never closes, so this stays the last setting.
    idle_on = 1'b1;
    write_length(32'hFFFF_FFFF);
    add_member(80, MEMBER_CLEAN, 8'($urandom_range(0, 31)));
    settle();

    $display("Sent %0d bytes under %0d length settings, checked %0d words.",
             bytes_taken, length_writes, words_checked);
    $display("Member status: ok %0d, short %0d, bad header %0d, header crc %0d, empty %0d.",
             status_count[gzmh_pkg::ST_OK], status_count[gzmh_pkg::ST_SHORT],
             status_count[gzmh_pkg::ST_HDR], status_count[gzmh_pkg::ST_HCRC],
             status_count[gzmh_pkg::ST_EMPTY]);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
